// ----- rtl/core/bgd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CSR_INDEX_WIDTH     = 8;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int DEBOUNCE_WIDTH      = 8;
   localparam int LIMIT_WIDTH         = 16;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET  = 8'd5;
   localparam logic [LIMIT_WIDTH-1:0]    LONGPRESS_RESET = 16'd50;
   localparam logic [LIMIT_WIDTH-1:0]    CLICK_GAP_RESET = 16'd40;
   localparam logic                      PRESSED_RESET   = 1'b0;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DEBOUNCE  = 8'd0,
      REG_LONGPRESS = 8'd1,
      REG_CLICK_GAP = 8'd2,
      REG_PRESSED   = 8'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      GESTURE_NONE       = 3'd0,
      GESTURE_SINGLE     = 3'd1,
      GESTURE_DOUBLE     = 3'd2,
      GESTURE_LONG_START = 3'd3,
      GESTURE_LONG_END   = 3'd4
   } gesture_type;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_samples;
      logic [LIMIT_WIDTH-1:0]    longpress_samples;
      logic [LIMIT_WIDTH-1:0]    click_gap_samples;
      logic                      pressed_level;
   } cfg_type;

   typedef struct packed {
      logic        key_down;
      gesture_type gesture;
   } result_type;

endpackage

// ----- rtl/core/bgd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_core
// Debounce and gesture state; computes one result word per accepted sample.
// ----------------------------------------------------------------------------
module bgd_core #(
   parameter int TIMER_WIDTH = bgd_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sample_accept,
   input  logic                 raw_level,
   input  logic                 enabled,
   input  bgd_pkg::cfg_type     cfg,
   output bgd_pkg::result_type  result
);
   import bgd_pkg::*;

   // compare width covers both the timers and the 16-bit limits
   localparam int CMP_WIDTH = (TIMER_WIDTH > LIMIT_WIDTH) ? TIMER_WIDTH : LIMIT_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [DEBOUNCE_WIDTH-1:0] EQUAL_MAX = {DEBOUNCE_WIDTH{1'b1}};

   logic                      previous_raw_ff, previous_raw_in;
   logic                      stable_level_ff, stable_level_in;
   logic [DEBOUNCE_WIDTH-1:0] equal_count_ff,  equal_count_in;
   logic [TIMER_WIDTH-1:0]    hold_timer_ff,   hold_timer_in;
   logic [TIMER_WIDTH-1:0]    gap_timer_ff,    gap_timer_in;
   logic                      have_release_ff, have_release_in;
   logic [1:0]                clicks_seen_ff,  clicks_seen_in;
   logic                      long_active_ff,  long_active_in;

   logic [CMP_WIDTH-1:0] longpress_ext, click_gap_ext;
   logic [TIMER_WIDTH-1:0] hold_inc, gap_inc;
   logic down;
   gesture_type gesture;

   assign longpress_ext = CMP_WIDTH'(cfg.longpress_samples);
   assign click_gap_ext = CMP_WIDTH'(cfg.click_gap_samples);
   assign hold_inc = (hold_timer_ff == TIMER_MAX) ? TIMER_MAX : hold_timer_ff + 1'b1;
   assign gap_inc  = (gap_timer_ff == TIMER_MAX) ? TIMER_MAX : gap_timer_ff + 1'b1;

   always_comb begin
      previous_raw_in = previous_raw_ff;
      stable_level_in = stable_level_ff;
      equal_count_in  = equal_count_ff;
      hold_timer_in   = hold_inc;
      gap_timer_in    = gap_inc;
      have_release_in = have_release_ff;
      clicks_seen_in  = clicks_seen_ff;
      long_active_in  = long_active_ff;
      gesture         = GESTURE_NONE;
      down            = 1'b0;

      if (!enabled) begin
         clicks_seen_in  = 2'd0;
         long_active_in  = 1'b0;
         have_release_in = 1'b0;
         gap_timer_in    = TIMER_MAX;
         down            = (raw_level == cfg.pressed_level);
      end else begin
         if (raw_level == previous_raw_ff) begin
            if (equal_count_ff != EQUAL_MAX) equal_count_in = equal_count_ff + 1'b1;
         end else begin
            previous_raw_in = raw_level;
            equal_count_in  = '0;
         end

         if (equal_count_in >= cfg.debounce_samples && raw_level != stable_level_ff) begin
            stable_level_in = raw_level;
            if (raw_level == cfg.pressed_level) begin
               hold_timer_in  = '0;
               long_active_in = 1'b0;
            end else if (!long_active_ff) begin
               if (have_release_ff && CMP_WIDTH'(gap_inc) < click_gap_ext) begin
                  clicks_seen_in = clicks_seen_ff + 2'd1;
                  if (clicks_seen_in == 2'd2) begin
                     gesture         = GESTURE_DOUBLE;
                     clicks_seen_in  = 2'd0;
                     have_release_in = 1'b0;
                     gap_timer_in    = TIMER_MAX;
                  end
               end else begin
                  // lone release: open a new gap
                  clicks_seen_in  = 2'd1;
                  have_release_in = 1'b1;
                  gap_timer_in    = '0;
               end
            end else begin
               long_active_in = 1'b0;
               gesture        = GESTURE_LONG_END;
            end
         end

         down = (stable_level_in == cfg.pressed_level);

         if (!down && clicks_seen_in == 2'd1 && CMP_WIDTH'(gap_timer_in) >= click_gap_ext) begin
            gesture        = GESTURE_SINGLE;
            clicks_seen_in = 2'd0;
         end

         if (down && !long_active_in && CMP_WIDTH'(hold_timer_in) >= longpress_ext) begin
            long_active_in = 1'b1;
            clicks_seen_in = 2'd0;
            gesture        = GESTURE_LONG_START;
         end
      end
   end

   assign result.key_down = down;
   assign result.gesture  = gesture;

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff <= 1'b1;
         stable_level_ff <= 1'b1;
         equal_count_ff  <= '0;
         hold_timer_ff   <= '0;
         gap_timer_ff    <= TIMER_MAX;
         have_release_ff <= 1'b0;
         clicks_seen_ff  <= 2'd0;
         long_active_ff  <= 1'b0;
      end else if (sample_accept) begin
         previous_raw_ff <= previous_raw_in;
         stable_level_ff <= stable_level_in;
         equal_count_ff  <= equal_count_in;
         hold_timer_ff   <= hold_timer_in;
         gap_timer_ff    <= gap_timer_in;
         have_release_ff <= have_release_in;
         clicks_seen_ff  <= clicks_seen_in;
         long_active_ff  <= long_active_in;
      end
   end

endmodule

// ----- rtl/core/bgd_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_out_reg
// Output register with one skid entry; keeps the input side moving while
// the result side stalls.
// ----------------------------------------------------------------------------
module bgd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bgd_pkg::result_type  load_word,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bgd_pkg::result_type  rsp_word
);
   import bgd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_word_ff,  main_word_in;
   result_type skid_word_ff,  skid_word_in;
   logic       take;

   assign take = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!main_valid_ff || take) begin
            main_word_in  = load_word;
            main_valid_in = 1'b1;
         end else begin
            skid_word_in  = load_word;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_word_ff;

endmodule

// ----- rtl/core/button_gesture_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector
// Key debouncer with click, double click and long-press classification.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  req     | req_valid / req_stall | req_raw_level, req_enabled
//  rsp     | rsp_valid / rsp_stall | rsp_key_down, rsp_gesture
//  csr     | csr_valid / csr_ready | csr_index, csr_data
//
//  One sample word per cycle while req_stall is low; its result word is registered.
//  The throughput is set by the single state update in bgd_core.
//  Synchronous reset restores register defaults and the released key state.
//  A stalled result is held in the output register; one more word goes to a
//  skid entry, and req_stall rises only while that entry is occupied.
// ----------------------------------------------------------------------------
module button_gesture_detector #(
   parameter int TIMER_WIDTH = bgd_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_raw_level,
   input  logic                                 req_enabled,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_key_down,
   output logic [2:0]                           rsp_gesture,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bgd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bgd_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import bgd_pkg::*;

   cfg_type    cfg_ff;
   logic       sample_accept;
   logic       buf_full;
   result_type core_word;
   result_type out_word;

   assign csr_ready     = 1'b1;
   assign req_stall     = buf_full;
   assign sample_accept = req_valid && !buf_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_samples  <= DEBOUNCE_RESET;
         cfg_ff.longpress_samples <= LONGPRESS_RESET;
         cfg_ff.click_gap_samples <= CLICK_GAP_RESET;
         cfg_ff.pressed_level     <= PRESSED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DEBOUNCE:  cfg_ff.debounce_samples  <= csr_data[DEBOUNCE_WIDTH-1:0];
            REG_LONGPRESS: cfg_ff.longpress_samples <= csr_data[LIMIT_WIDTH-1:0];
            REG_CLICK_GAP: cfg_ff.click_gap_samples <= csr_data[LIMIT_WIDTH-1:0];
            REG_PRESSED:   cfg_ff.pressed_level     <= csr_data[0];
            default: ;  // unknown index ignored
         endcase
      end
   end

   bgd_core #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .sample_accept(sample_accept),
      .raw_level    (req_raw_level),
      .enabled      (req_enabled),
      .cfg          (cfg_ff),
      .result       (core_word)
   );

   bgd_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (sample_accept),
      .load_word(core_word),
      .full     (buf_full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (out_word)
   );

   assign rsp_key_down = out_word.key_down;
   assign rsp_gesture  = out_word.gesture;

   // skid entry only fills behind a held output word
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry occupied with empty output register");

   a_accept_fills_output: assert property (@(posedge clock) disable iff (reset)
      (sample_accept && !rsp_valid) |=> rsp_valid)
      else $error("accepted word did not reach output register");

   a_long_start_pressed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gesture == GESTURE_LONG_START) |-> rsp_key_down)
      else $error("long press start with key released");

   a_release_gestures: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_gesture == GESTURE_SINGLE || rsp_gesture == GESTURE_DOUBLE ||
                     rsp_gesture == GESTURE_LONG_END)) |-> !rsp_key_down)
      else $error("release gesture with key down");

endmodule

// ----- bench/button_gesture_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_tb
// Self-checking bench for the key debouncer and gesture classifier. A short
// table of sample and register words runs first. Randomized press, release,
// bounce and disable sequences follow under several register settings.
// Sample-side gaps and result-side stalls are random but for the last two phases.
// Each result word is compared with an in-bench model of the classifier or a typed row.
// ----------------------------------------------------------------------------
module button_gesture_detector_tb;
   import bgd_pkg::*;

   localparam int TW          = TIMER_WIDTH_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int MAX_PRINTED = 100;
   localparam int PHASES      = 6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 8'hFF;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic                       raw;
      logic                       en;
      logic                       typed;
      logic                       exp_down;
      gesture_type                exp_gesture;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } row_type;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic                       req_raw_level = 1'b0;
   logic                       req_enabled   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic                       rsp_key_down;
   logic [2:0]                 rsp_gesture;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index     = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data      = '0;

   // classifier model state
   cfg_type                   cfg_q;
   logic                      last_raw_q;
   logic                      stable_q;
   logic [DEBOUNCE_WIDTH-1:0] equal_q;
   logic [TW-1:0]             hold_q;
   logic [TW-1:0]             gap_q;
   logic                      release_seen_q;
   logic [1:0]                clicks_q;
   logic                      long_on_q;

   result_type pending_gestures[$];
   int         error_count   = 0;
   int         send_idle_pct = 0;
   int         stall_pct     = 0;
   int         samples_sent  = 0;
   int         quiet_cycles  = 0;

   // expectation typed in only where obvious; the rest comes from the model
   row_type directed_rows [27] = '{
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b1, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_WRITE,  1'b0, 1'b0, 1'b0, 1'b0, GESTURE_NONE, REG_DEBOUNCE,  16'd0},
      '{ROW_WRITE,  1'b0, 1'b0, 1'b0, 1'b0, GESTURE_NONE, REG_LONGPRESS, 16'd1},
      '{ROW_WRITE,  1'b0, 1'b0, 1'b0, 1'b0, GESTURE_NONE, REG_CLICK_GAP, 16'd6},
      '{ROW_WRITE,  1'b0, 1'b0, 1'b0, 1'b0, GESTURE_NONE, REG_UNUSED,    16'hFFFF},
      // long press start and end
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      // double click
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      // click, long press inside the gap, then a release in the open gap
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b1, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      // flip the pressed level with the key up
      '{ROW_WRITE,  1'b0, 1'b0, 1'b0, 1'b0, GESTURE_NONE, REG_PRESSED,   16'd1},
      '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0},
      '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, GESTURE_NONE, 8'd0, 16'd0}
   };

   // per phase: debounce, long press, click gap, pressed level
   logic [CSR_DATA_WIDTH-1:0] phase_regs [PHASES][4] = '{
      '{16'd2,   16'd12,   16'd10,   16'd0},
      '{16'd0,   16'd0,    16'd0,    16'd1},
      '{16'd1,   16'hFFFF, 16'hFFFF, 16'd0},
      '{16'd255, 16'd3,    16'd5,    16'd1},
      '{16'hFF04, 16'd20,  16'd25,   16'hFFFE},
      '{16'd3,   16'd8,    16'd30,   16'd1}
   };
   // long debounce runs overshoot their budget by up to one run
   int phase_budget [PHASES] = '{110, 110, 110, 400, 120, 120};

   button_gesture_detector #(
      .TIMER_WIDTH(TW)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_raw_level(req_raw_level),
      .req_enabled  (req_enabled),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_key_down (rsp_key_down),
      .rsp_gesture  (rsp_gesture),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
   endtask

   // one sample tick of the classifier
   task automatic classify_sample(input logic raw, input logic en, output result_type res);
      logic        down;
      gesture_type g;
      g = GESTURE_NONE;
      if (hold_q != '1) hold_q++;
      if (gap_q != '1) gap_q++;
      if (!en) begin
         clicks_q       = '0;
         long_on_q      = 1'b0;
         release_seen_q = 1'b0;
         gap_q          = '1;
         down           = (raw == cfg_q.pressed_level);
      end else begin
         if (raw == last_raw_q) begin
            if (equal_q != '1) equal_q++;
         end else begin
            last_raw_q = raw;
            equal_q    = '0;
         end
         if (equal_q >= cfg_q.debounce_samples && raw != stable_q) begin
            stable_q = raw;
            if (stable_q == cfg_q.pressed_level) begin
               hold_q    = '0;
               long_on_q = 1'b0;
            end else if (!long_on_q) begin
               // a release in an open gap counts but leaves the gap running
               if (release_seen_q && gap_q < cfg_q.click_gap_samples) begin
                  clicks_q = clicks_q + 2'd1;
                  if (clicks_q == 2'd2) begin
                     g              = GESTURE_DOUBLE;
                     clicks_q       = '0;
                     release_seen_q = 1'b0;
                     gap_q          = '1;
                  end
               end else begin
                  clicks_q       = 2'd1;
                  release_seen_q = 1'b1;
                  gap_q          = '0;
               end
            end else begin
               long_on_q = 1'b0;
               g         = GESTURE_LONG_END;
            end
         end
         down = (stable_q == cfg_q.pressed_level);
         if (!down && clicks_q == 2'd1 && gap_q >= cfg_q.click_gap_samples) begin
            g        = GESTURE_SINGLE;
            clicks_q = '0;
         end
         if (down && !long_on_q && hold_q >= cfg_q.longpress_samples) begin
            long_on_q = 1'b1;
            clicks_q  = '0;
            g         = GESTURE_LONG_START;
         end
      end
      res.key_down = down;
      res.gesture  = g;
   endtask

   // called at a falling edge, returns at the falling edge after the accept
   task automatic send_sample(input logic raw, input logic en, input logic typed = 1'b0,
                              input logic exp_down = 1'b0,
                              input gesture_type exp_g = GESTURE_NONE);
      result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_level <= raw;
      req_enabled   <= en;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_sample(raw, en, res);
      if (typed) begin
         res.key_down = exp_down;
         res.gesture  = exp_g;
      end
      pending_gestures.push_back(res);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      req_valid <= 1'b0;
      while (pending_gestures.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         REG_DEBOUNCE:  cfg_q.debounce_samples  = data[DEBOUNCE_WIDTH-1:0];
         REG_LONGPRESS: cfg_q.longpress_samples = data[LIMIT_WIDTH-1:0];
         REG_CLICK_GAP: cfg_q.click_gap_samples = data[LIMIT_WIDTH-1:0];
         REG_PRESSED:   cfg_q.pressed_level     = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly press/release runs sized around the current limits, plus noise,
   // disabled stretches and glitches no longer than the debounce count
   task automatic run_phase(input int budget, input int deb, input int long_lim,
                            input int gap_lim);
      int   start;
      int   span;
      logic lvl;
      start = samples_sent;
      lvl   = 1'($urandom_range(0, 1));
      while (samples_sent - start < budget) begin
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 6))
                  send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            1: repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)), 1'b0);
            2: repeat ($urandom_range(0, deb)) send_sample(~lvl, 1'b1);
            default: begin
               lvl = ~lvl;
               repeat ($urandom_range(0, 3)) send_sample(1'($urandom_range(0, 1)), 1'b1);
               span = $urandom_range(0, 1) ? long_lim : gap_lim;
               if (span > 40) span = 40;
               repeat (deb + 1 + $urandom_range(0, 2 * span + 2)) send_sample(lvl, 1'b1);
            end
         endcase
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gestures.size() == 0) begin
            report_mismatch($sformatf("unexpected word key_down=%0b gesture=%0d",
                                      rsp_key_down, rsp_gesture));
         end else begin
            want = pending_gestures.pop_front();
            if (rsp_key_down !== want.key_down)
               report_mismatch($sformatf("key_down %0b, want %0b",
                                         rsp_key_down, want.key_down));
            if (rsp_gesture !== want.gesture)
               report_mismatch($sformatf("gesture %0d, want %0d",
                                         rsp_gesture, want.gesture));
         end
      end
   end

   // cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("button_gesture_detector_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      row_type row;
      cfg_q.debounce_samples  = DEBOUNCE_RESET;
      cfg_q.longpress_samples = LONGPRESS_RESET;
      cfg_q.click_gap_samples = CLICK_GAP_RESET;
      cfg_q.pressed_level     = PRESSED_RESET;
      last_raw_q     = ~PRESSED_RESET;
      stable_q       = ~PRESSED_RESET;
      equal_q        = '0;
      hold_q         = '0;
      gap_q          = '1;
      release_seen_q = 1'b0;
      clicks_q       = '0;
      long_on_q      = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      stall_pct     = 71;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) write_reg(row.index, row.data);
         else send_sample(row.raw, row.en, row.typed, row.exp_down, row.exp_gesture);
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p < 2) begin
            send_idle_pct = 8;
            stall_pct     = 71;
         end else if (p < 4) begin
            send_idle_pct = 71;
            stall_pct     = 8;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         write_reg(REG_DEBOUNCE,  phase_regs[p][0]);
         write_reg(REG_LONGPRESS, phase_regs[p][1]);
         write_reg(REG_CLICK_GAP, phase_regs[p][2]);
         write_reg(REG_PRESSED,   phase_regs[p][3]);
         run_phase(phase_budget[p], int'(phase_regs[p][0][DEBOUNCE_WIDTH-1:0]),
                   int'(phase_regs[p][1]), int'(phase_regs[p][2]));
      end

      req_valid <= 1'b0;
      while (pending_gestures.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0) $display("button_gesture_detector_tb: done, clean");
      else $display("button_gesture_detector_tb: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/bgd_pkg.sv
rtl/core/bgd_core.sv
rtl/core/bgd_out_reg.sv
rtl/core/button_gesture_detector.sv
bench/button_gesture_detector_tb.sv
